/* hdl/reev_pkg.sv */
package reev_pkg;

   localparam int StackDepth = 16;
   localparam int SpW = $clog2(StackDepth);
   localparam int CntW = $clog2(StackDepth + 1);
   localparam int CsrIdxW = 2;

   localparam logic [4:0] OP_DATA   = 5'd0;
   localparam logic [4:0] OP_ADD    = 5'd1;
   localparam logic [4:0] OP_SUB    = 5'd2;
   localparam logic [4:0] OP_MUL    = 5'd3;
   localparam logic [4:0] OP_DIV    = 5'd4;
   localparam logic [4:0] OP_MOD    = 5'd5;
   localparam logic [4:0] OP_ASR    = 5'd6;
   localparam logic [4:0] OP_SHL    = 5'd7;
   localparam logic [4:0] OP_XOR    = 5'd8;
   localparam logic [4:0] OP_AND    = 5'd9;
   localparam logic [4:0] OP_OR     = 5'd10;
   localparam logic [4:0] OP_NOT    = 5'd11;
   localparam logic [4:0] OP_NEG    = 5'd12;
   localparam logic [4:0] OP_SWAP   = 5'd13;
   localparam logic [4:0] OP_PUSH   = 5'd14;
   localparam logic [4:0] OP_PUSHU  = 5'd18;
   localparam logic [4:0] OP_SYM    = 5'd19;
   localparam logic [4:0] OP_POPB   = 5'd20;
   localparam logic [4:0] OP_POPW   = 5'd21;
   localparam logic [4:0] OP_RESV   = 5'd22;
   localparam logic [4:0] OP_END    = 5'd23;
   localparam logic [4:0] OP_SYMDEF = 5'd24;
   localparam logic [4:0] OP_ORG    = 5'd25;
   localparam logic [4:0] OP_ORGU   = 5'd28;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_BYTE = 3'd1;
   localparam logic [2:0] KIND_WORD = 3'd2;
   localparam logic [2:0] KIND_FILL = 3'd3;
   localparam logic [2:0] KIND_SEEK = 3'd4;

   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_UNDER = 3'd1;
   localparam logic [2:0] ERR_OVER  = 3'd2;
   localparam logic [2:0] ERR_BYTE  = 3'd3;
   localparam logic [2:0] ERR_UDEF  = 3'd4;
   localparam logic [2:0] ERR_LEFT  = 3'd5;
   localparam logic [2:0] ERR_DIV0  = 3'd6;
   localparam logic [2:0] ERR_BADOP = 3'd7;

   localparam logic [1:0] SEG_UDEF = 2'd3;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [15:0] operand;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] out_data;
      logic [15:0] out_address;
      logic [2:0]  error;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch command, read top of stack
      logic read2;    // read second entry
      logic div_start;
      logic execute;  // compute result, commit state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic need_div;
   } sts_type;

endpackage

/* hdl/reev_if.sv */
interface reev_req_if;
   logic              valid;
   logic              ready;
   reev_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface reev_rsp_if;
   logic              valid;
   logic              ready;
   reev_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/reev_ram.sv */
module reev_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* hdl/reev_div.sv */
module reev_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient,
   output logic [15:0] remainder
);
   logic [15:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [15:0] ua, ub;

   assign ua = dividend[15] ? 16'(-dividend) : dividend;
   assign ub = divisor[15] ? 16'(-divisor) : divisor;
   assign trial = {r_ff[15:0], q_ff[15]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; qneg_in = qneg_ff; rneg_in = rneg_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = ua; r_in = '0; d_in = ub; cnt_in = 5'd16; busy_in = 1'b1;
         qneg_in = dividend[15] ^ divisor[15];
         rneg_in = dividend[15];
      end else if (busy_ff) begin
         if (!trial[16]) begin
            r_in = trial;
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = {r_ff[15:0], q_ff[15]};
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   assign done = done_ff;
   assign quotient = qneg_ff ? 16'(-q_ff) : q_ff;
   assign remainder = rneg_ff ? 16'(-r_ff[15:0]) : r_ff[15:0];
endmodule

/* hdl/reev_dp.sv */
module reev_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  reev_pkg::cmd_type    cmd,
   output reev_pkg::sts_type    sts,
   input  reev_pkg::req_type    req,
   output reev_pkg::rsp_type    rsp,
   input  logic                 csr_write,
   input  logic [reev_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0]          csr_data
);
   localparam int SpW = reev_pkg::SpW;
   localparam int CntW = reev_pkg::CntW;

   logic [15:0] base_ff [4];
   logic [15:0] pos_ff [4];
   logic [15:0] pos_in;
   logic        pos_we;
   logic [1:0]  seg_ff, seg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [4:0]  op_ff;
   logic [15:0] v_ff, top_ff, r_ff, l_ff;

   logic        wr_en;
   logic [SpW-1:0] wr_addr, rd_addr;
   logic [15:0] wr_data, rd_data;

   logic        wr2_pend_ff, wr2_pend_in;
   logic [15:0] wr2_data_ff, wr2_data_in;
   logic [SpW-1:0] wr2_addr_ff, wr2_addr_in;

   logic        div_done;
   logic [15:0] quo, rem;
   logic        at_read2_ff;
   logic        got_ff;

   reev_ram #(.Width(16), .Depth(reev_pkg::StackDepth)) u_stack (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   reev_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(l_ff), .divisor(r_ff), .done(div_done),
      .quotient(quo), .remainder(rem)
   );

   assign sts.div_done = div_done;
   assign sts.need_div = (op_ff == reev_pkg::OP_DIV || op_ff == reev_pkg::OP_MOD)
                         && cnt_ff >= CntW'(2) && r_ff != 16'd0;

   // read: load->top, read2->second
   always_comb begin
      rd_addr = SpW'(cnt_ff - CntW'(1));
      if (cmd.read2) begin
         rd_addr = SpW'(cnt_ff - CntW'(2));
      end
   end

   always_ff @(posedge clock) begin
      at_read2_ff <= cmd.read2;
      got_ff <= cmd.load;
      if (cmd.load) begin
         op_ff <= req.opcode;
         v_ff <= req.operand;
      end
      if (got_ff) begin
         r_ff <= rd_data;
         top_ff <= rd_data;
      end
      if (at_read2_ff) begin
         l_ff <= rd_data;
      end
   end

   logic [15:0] res, x, padd;
   logic [1:0]  seg, ns;
   logic [15:0] pos;
   logic [31:0] prod;
   logic [2:0]  kind, err;
   logic [15:0] data, addr;

   assign prod = 32'(l_ff) * 32'(r_ff);

   always_comb begin
      seg = seg_ff;
      pos = pos_ff[seg];
      kind = reev_pkg::KIND_NONE; data = '0; addr = pos; err = reev_pkg::ERR_OK;
      res = '0; x = '0; padd = '0;
      ns = 2'(op_ff - reev_pkg::OP_ORG);
      seg_in = seg_ff; cnt_in = cnt_ff;
      pos_in = pos; pos_we = 1'b0;
      wr_en = 1'b0; wr_addr = SpW'(cnt_ff - CntW'(1)); wr_data = '0;
      wr2_pend_in = 1'b0; wr2_data_in = wr2_data_ff; wr2_addr_in = wr2_addr_ff;

      if (wr2_pend_ff) begin
         wr_en = 1'b1; wr_addr = wr2_addr_ff; wr_data = wr2_data_ff;
      end

      if (op_ff >= reev_pkg::OP_ADD && op_ff <= reev_pkg::OP_OR) begin
         if (cnt_ff < CntW'(2)) begin
            err = reev_pkg::ERR_UNDER;
         end else begin
            case (op_ff)
               reev_pkg::OP_ADD: res = l_ff + r_ff;
               reev_pkg::OP_SUB: res = l_ff - r_ff;
               reev_pkg::OP_MUL: res = prod[15:0];
               reev_pkg::OP_DIV: res = quo;
               reev_pkg::OP_MOD: res = rem;
               reev_pkg::OP_ASR: res = (r_ff > 16'd15) ? {16{l_ff[15]}}
                                       : 16'($signed(l_ff) >>> r_ff[3:0]);
               reev_pkg::OP_SHL: res = (r_ff > 16'd15) ? 16'd0 : (l_ff << r_ff[3:0]);
               reev_pkg::OP_XOR: res = l_ff ^ r_ff;
               reev_pkg::OP_AND: res = l_ff & r_ff;
               default: res = l_ff | r_ff;
            endcase
            if ((op_ff == reev_pkg::OP_DIV || op_ff == reev_pkg::OP_MOD)
                && r_ff == 16'd0) begin
               err = reev_pkg::ERR_DIV0;
            end else if (cmd.execute) begin
               wr_en = 1'b1; wr_addr = SpW'(cnt_ff - CntW'(2)); wr_data = res;
               cnt_in = cnt_ff - CntW'(1);
            end
         end
      end else if (op_ff == reev_pkg::OP_NOT || op_ff == reev_pkg::OP_NEG) begin
         if (cnt_ff == '0) begin
            err = reev_pkg::ERR_UNDER;
         end else if (cmd.execute) begin
            wr_en = 1'b1;
            wr_data = (op_ff == reev_pkg::OP_NOT) ? ~top_ff : 16'(-top_ff);
         end
      end else if (op_ff == reev_pkg::OP_SWAP) begin
         if (cnt_ff < CntW'(2)) begin
            err = reev_pkg::ERR_UNDER;
         end else if (cmd.execute) begin
            wr_en = 1'b1; wr_data = l_ff;
            wr2_pend_in = 1'b1; wr2_data_in = r_ff;
            wr2_addr_in = SpW'(cnt_ff - CntW'(2));
         end
      end else if (op_ff >= reev_pkg::OP_PUSH && op_ff <= reev_pkg::OP_SYM) begin
         if (cnt_ff >= CntW'(reev_pkg::StackDepth)) begin
            err = reev_pkg::ERR_OVER;
         end else if (cmd.execute) begin
            padd = (op_ff > reev_pkg::OP_PUSH && op_ff <= reev_pkg::OP_PUSHU)
                   ? base_ff[2'(op_ff - reev_pkg::OP_PUSH - 5'd1)] : 16'd0;
            wr_en = 1'b1; wr_addr = SpW'(cnt_ff); wr_data = v_ff + padd;
            cnt_in = cnt_ff + CntW'(1);
         end
      end else if (op_ff == reev_pkg::OP_POPB || op_ff == reev_pkg::OP_POPW) begin
         x = top_ff;
         if (cnt_ff == '0) begin
            err = reev_pkg::ERR_UNDER;
         end else if (op_ff == reev_pkg::OP_POPB && !(x <= 16'd127 || x >= 16'hFF80)) begin
            err = reev_pkg::ERR_BYTE;
         end else if (seg == reev_pkg::SEG_UDEF) begin
            err = reev_pkg::ERR_UDEF;
         end else begin
            cnt_in = cnt_ff - CntW'(1);
            pos_we = 1'b1;
            if (op_ff == reev_pkg::OP_POPB) begin
               kind = reev_pkg::KIND_BYTE; data = {8'd0, x[7:0]}; pos_in = pos + 16'd1;
            end else begin
               kind = reev_pkg::KIND_WORD; data = x; pos_in = pos + 16'd2;
            end
         end
      end else if (op_ff == reev_pkg::OP_DATA) begin
         if (seg == reev_pkg::SEG_UDEF) begin
            err = reev_pkg::ERR_UDEF;
         end else begin
            kind = reev_pkg::KIND_BYTE; data = {8'd0, v_ff[7:0]};
            pos_we = 1'b1; pos_in = pos + 16'd1;
         end
      end else if (op_ff == reev_pkg::OP_RESV) begin
         pos_we = 1'b1; pos_in = pos + v_ff;
         if (seg != reev_pkg::SEG_UDEF && !v_ff[15] && v_ff != 16'd0) begin
            kind = reev_pkg::KIND_FILL; data = v_ff;
         end
      end else if (op_ff == reev_pkg::OP_END) begin
         if (cnt_ff != '0) begin
            err = reev_pkg::ERR_LEFT;
         end
      end else if (op_ff == reev_pkg::OP_SYMDEF) begin
         kind = reev_pkg::KIND_NONE;
      end else if (op_ff >= reev_pkg::OP_ORG && op_ff <= reev_pkg::OP_ORGU) begin
         seg_in = ns; seg = ns;
         pos_we = 1'b1; pos_in = v_ff;
         kind = reev_pkg::KIND_SEEK;
         addr = (ns == reev_pkg::SEG_UDEF) ? 16'd0 : base_ff[ns] + v_ff;
      end else begin
         err = reev_pkg::ERR_BADOP;
      end

      if (err != reev_pkg::ERR_OK) begin
         kind = reev_pkg::KIND_NONE; data = '0; addr = pos;
         cnt_in = cnt_ff; pos_we = 1'b0; seg_in = seg_ff; wr2_pend_in = 1'b0;
         if (!wr2_pend_ff) begin
            wr_en = 1'b0;
         end
      end
      if (!cmd.execute) begin
         cnt_in = cnt_ff; pos_we = 1'b0; seg_in = seg_ff; wr2_pend_in = 1'b0;
         if (!wr2_pend_ff) begin
            wr_en = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            base_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         seg_ff <= '0;
         cnt_ff <= '0;
         wr2_pend_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            base_ff[csr_index] <= csr_data;
         end
         if (pos_we) begin
            pos_ff[seg] <= pos_in;
         end
         seg_ff <= seg_in;
         cnt_ff <= cnt_in;
         wr2_pend_ff <= wr2_pend_in;
      end
      wr2_data_ff <= wr2_data_in;
      wr2_addr_ff <= wr2_addr_in;
      if (cmd.execute) begin
         rsp <= '{kind: kind, out_data: data, out_address: addr, error: err};
      end
   end
endmodule

/* hdl/reev_ctrl.sv */
module reev_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output reev_pkg::cmd_type cmd,
   input  reev_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      S_IDLE, S_TOP, S_SECOND, S_DECIDE, S_DIV, S_EXEC, S_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = req_valid && req_ready;
      cmd.read2 = (state_ff == S_TOP);
      cmd.div_start = (state_ff == S_DECIDE) && sts.need_div;
      cmd.execute = (state_ff == S_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  state_ff <= S_TOP;
               end
            end
            S_TOP: state_ff <= S_SECOND;
            S_SECOND: state_ff <= S_DECIDE;
            S_DECIDE: state_ff <= sts.need_div ? S_DIV : S_EXEC;
            S_DIV: begin
               if (sts.div_done) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_HOLD;
            end
            S_HOLD: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hdl/relocation_expression_evaluator_top.sv */
// From accepted word to result word: top read, second read, decide, divide (div and mod with a nonzero
// divisor only, 16-step serial divider), execute. A new word is taken only after the last is done and its result taken.
// The stack memory has one read port, so top and second entries are read in turn.
// Reset (synchronous): stack empty, code segment current, positions and bases zero.
// A result word waits in the output register until taken.
module relocation_expression_evaluator_top (
   input  logic        clock,
   input  logic        reset,
   reev_req_if.sink    req,
   reev_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [reev_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0] csr_data
);
   reev_pkg::cmd_type cmd;
   reev_pkg::sts_type sts;

   reev_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .sts(sts)
   );

   reev_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req(req.payload), .rsp(rsp.payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.execute, cmd.div_start}))
      else $error("controller commands overlap");
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp.valid)
      else $error("result missing after execute");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input taken while result pending");
endmodule
